>>> rtl/core/integer_to_radix_text_defines.svh
// Assertion macros shared by the integer to radix text converter.
// Every assertion is clocked by clk_i and is off while rst_ni is low.
`ifndef INTEGER_TO_RADIX_TEXT_DEFINES_SVH
`define INTEGER_TO_RADIX_TEXT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define IRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define IRT_ASSERT_IMPL(lbl, ante, cons, msg) \
  `IRT_ASSERT(lbl, (ante) |-> (cons), msg)
`define IRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  `IRT_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define IRT_ASSERT(lbl, prop, msg)
`define IRT_ASSERT_IMPL(lbl, ante, cons, msg)
`define IRT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/irt_pkg.sv
// Shared types and constants of the integer to radix text converter.
// Used by irt_ctrl, irt_datapath and integer_to_radix_text; no dependencies.
package irt_pkg;

  localparam int unsigned ChunkBits = 8;
  localparam int unsigned RadixW    = 5;
  localparam int unsigned ValueW    = 64;
  localparam int unsigned CharW     = 8;

  localparam logic [RadixW-1:0] RadixReset = 5'd10;
  localparam logic [CharW-1:0]  MinusChar  = 8'h2D;

  localparam logic [CharW-1:0] DigitChars [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StStore,
    StPrep,
    StEmit
  } irt_state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic prep;
    logic emit;
  } irt_cmd_t;

  typedef struct packed {
    logic chunk_last;
    logic digits_done;
    logic ptr_zero;
  } irt_status_t;

endpackage

>>> rtl/core/irt_ctrl.sv
// Sequencer of the converter: division chunks, digit stores and emission.
// Depends on irt_pkg and integer_to_radix_text_defines.svh.
`include "integer_to_radix_text_defines.svh"

module irt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  irt_pkg::irt_status_t status_i,
  output irt_pkg::irt_cmd_t    cmd_o
);

  irt_pkg::irt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= irt_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      irt_pkg::StIdle: begin
        if (start) state_d = irt_pkg::StDiv;
      end
      irt_pkg::StDiv: begin
        if (status_i.chunk_last) state_d = irt_pkg::StStore;
      end
      irt_pkg::StStore: begin
        state_d = status_i.digits_done ? irt_pkg::StPrep : irt_pkg::StDiv;
      end
      irt_pkg::StPrep: begin
        state_d = irt_pkg::StEmit;
      end
      irt_pkg::StEmit: begin
        if (status_i.ptr_zero) state_d = irt_pkg::StIdle;
      end
      default: begin
        state_d = irt_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      irt_pkg::StIdle:  cmd_o.load     = start;
      irt_pkg::StDiv:   cmd_o.div_step = 1'b1;
      irt_pkg::StStore: cmd_o.store    = 1'b1;
      irt_pkg::StPrep:  cmd_o.prep     = 1'b1;
      irt_pkg::StEmit:  cmd_o.emit     = 1'b1;
      default:          cmd_o          = '0;
    endcase
  end

  assign busy = (state_q != irt_pkg::StIdle);

  `IRT_ASSERT_NEXT(a_start_enters_div, start && !busy, state_q == irt_pkg::StDiv,
                   "accepted request did not start division")
  `IRT_ASSERT_NEXT(a_emit_ends, (state_q == irt_pkg::StEmit) && status_i.ptr_zero,
                   state_q == irt_pkg::StIdle, "emission did not end after last digit")
  `IRT_ASSERT(a_cmd_exclusive, $onehot0(cmd_o), "more than one datapath command")

endmodule

>>> rtl/core/irt_datapath.sv
// Datapath: magnitude register with chunked division by the base, digit memory
// and output registers. Depends on irt_pkg and integer_to_radix_text_defines.svh.
`include "integer_to_radix_text_defines.svh"

module irt_datapath #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned MAX_DIGITS  = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  irt_pkg::irt_cmd_t                 cmd_i,
  output irt_pkg::irt_status_t              status_o,
  input  logic signed [irt_pkg::ValueW-1:0] value_i,
  input  logic                              radix_we_i,
  input  logic [irt_pkg::RadixW-1:0]        radix_wdata_i,
  output logic [irt_pkg::CharW-1:0]         character_o,
  output logic                              last_char_o,
  output logic                              char_valid_o
);

  localparam int unsigned MagBits  = VALUE_WIDTH - 1;
  localparam int unsigned NChunk   = (MagBits + irt_pkg::ChunkBits - 1) / irt_pkg::ChunkBits;
  localparam int unsigned MagW     = NChunk * irt_pkg::ChunkBits;
  localparam int unsigned ChunkCW  = (NChunk > 1) ? $clog2(NChunk) : 1;
  localparam int unsigned CntW     = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IdxW     = $clog2(MAX_DIGITS);

  logic [irt_pkg::RadixW-1:0] radix_q;
  logic [irt_pkg::RadixW-1:0] base;
  logic [MagW-1:0]            mag_q, mag_d;
  logic [3:0]                 rem_q, rem_d;
  logic [ChunkCW-1:0]         chunk_q;
  logic [CntW-1:0]            count_q;
  logic                       neg_q;
  logic [IdxW-1:0]            rd_ptr_q;
  logic [3:0]                 mem [MAX_DIGITS];
  logic [3:0]                 rdata_q;
  logic [IdxW-1:0]            raddr;
  logic                       re;
  logic [irt_pkg::CharW-1:0]  char_q;
  logic                       last_q, valid_q;

  // Sign handling; the most negative value saturates to the largest magnitude.
  logic [VALUE_WIDTH-1:0]     v;
  logic [VALUE_WIDTH-1:0]     absv;
  logic [MagBits-1:0]         mag_load;
  logic                       v_neg;

  assign v     = value_i[VALUE_WIDTH-1:0];
  assign v_neg = v[VALUE_WIDTH-1];
  assign absv  = v_neg ? (~v + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : v;

  always_comb begin
    if (v_neg && (v[VALUE_WIDTH-2:0] == '0)) begin
      mag_load = '1;
    end else begin
      mag_load = absv[MagBits-1:0];
    end
  end

  always_comb begin
    if (radix_q < 5'd2) begin
      base = 5'd2;
    end else if (radix_q > 5'd16) begin
      base = 5'd16;
    end else begin
      base = radix_q;
    end
  end

  // One chunk of restoring division: the top bits of the magnitude leave, the
  // quotient bits enter at the bottom, so after all chunks it holds the quotient.
  always_comb begin
    logic [irt_pkg::ChunkBits-1:0] top;
    logic [irt_pkg::ChunkBits-1:0] qbits;
    logic [3:0]                    r;
    logic [4:0]                    t;
    top   = mag_q[MagW-1 -: irt_pkg::ChunkBits];
    qbits = '0;
    r     = rem_q;
    for (int i = irt_pkg::ChunkBits - 1; i >= 0; i--) begin
      t = {r, top[i]};
      if (t >= base) begin
        qbits[i] = 1'b1;
        t        = t - base;
      end
      r = t[3:0];
    end
    mag_d = (mag_q << irt_pkg::ChunkBits) | MagW'(qbits);
    rem_d = r;
  end

  logic [CntW:0] cnt_next;
  logic [CntW:0] limit;
  assign cnt_next = {1'b0, count_q} + {{CntW{1'b0}}, 1'b1};
  assign limit    = (CntW+1)'(MAX_DIGITS) - {{CntW{1'b0}}, neg_q};

  assign status_o.chunk_last  = (chunk_q == ChunkCW'(NChunk - 1));
  assign status_o.digits_done = (mag_q == '0) || (cnt_next >= limit);
  assign status_o.ptr_zero    = (rd_ptr_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= irt_pkg::RadixReset;
      count_q <= '0;
      neg_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (radix_we_i) radix_q <= radix_wdata_i;
      if (cmd_i.load) begin
        count_q <= '0;
        neg_q   <= v_neg;
      end else if (cmd_i.store) begin
        count_q <= cnt_next[CntW-1:0];
      end
      valid_q <= (cmd_i.prep && neg_q) || cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q   <= MagW'(mag_load);
      rem_q   <= '0;
      chunk_q <= '0;
    end else if (cmd_i.div_step) begin
      mag_q   <= mag_d;
      rem_q   <= rem_d;
      chunk_q <= chunk_q + ChunkCW'(1);
    end else if (cmd_i.store) begin
      rem_q   <= '0;
      chunk_q <= '0;
    end
    if (cmd_i.prep) begin
      rd_ptr_q <= raddr;
    end else if (cmd_i.emit && !status_o.ptr_zero) begin
      rd_ptr_q <= raddr;
    end
    if (cmd_i.prep) begin
      char_q <= irt_pkg::MinusChar;
      last_q <= 1'b0;
    end else begin
      char_q <= irt_pkg::DigitChars[rdata_q];
      last_q <= status_o.ptr_zero;
    end
  end

  // Digits go in least significant first and are read back from the top.
  assign raddr = cmd_i.prep ? (count_q[IdxW-1:0] - IdxW'(1)) : (rd_ptr_q - IdxW'(1));
  assign re    = cmd_i.prep || (cmd_i.emit && !status_o.ptr_zero);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) mem[count_q[IdxW-1:0]] <= rem_q;
    if (re) rdata_q <= mem[raddr];
  end

  assign character_o  = char_q;
  assign last_char_o  = last_q;
  assign char_valid_o = valid_q;

  `IRT_ASSERT(a_count_bound, count_q <= CntW'(MAX_DIGITS), "digit count past capacity")
  `IRT_ASSERT_IMPL(a_last_is_digit, valid_q && last_q, char_q != irt_pkg::MinusChar,
                   "last character is a minus sign")
  `IRT_ASSERT_NEXT(a_store_advances, cmd_i.store, count_q != '0,
                   "digit count did not advance after a store")

endmodule

>>> rtl/core/integer_to_radix_text.sv
// Top level of the signed integer to radix text converter.
// Depends on irt_pkg, irt_ctrl and irt_datapath.
//
//  Channel   Signals                              Handshake
//  request   start, busy, value_i                 accepted when start and !busy
//  result    char_valid_o, character_o,           valid per character, no stall
//            last_char_o
//  config    radix_we_i, radix_wdata_i            written when radix_we_i is high
//
// A request divides the magnitude, split into C = ceil((VALUE_WIDTH-1)/8) chunks
// of 8 bits, by the base once per digit in the 8-bit-per-cycle divider and stores
// each remainder; then the characters leave one per cycle from the digit memory.
// Reset sets the base to ten; no clearing pass is needed. Results cannot be stalled.
module integer_to_radix_text #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned MAX_DIGITS  = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [irt_pkg::ValueW-1:0] value_i,
  input  logic                              radix_we_i,
  input  logic [irt_pkg::RadixW-1:0]        radix_wdata_i,
  output logic [irt_pkg::CharW-1:0]         character_o,
  output logic                              last_char_o,
  output logic                              char_valid_o
);

  irt_pkg::irt_cmd_t    cmd;
  irt_pkg::irt_status_t status;

  irt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  irt_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .value_i       (value_i),
    .radix_we_i    (radix_we_i),
    .radix_wdata_i (radix_wdata_i),
    .character_o   (character_o),
    .last_char_o   (last_char_o),
    .char_valid_o  (char_valid_o)
  );

endmodule
